// ----- rtl/core/point_scale_rotate_translate_macros.svh -----
// Assertion macros for the point transform RTL, used by psrt_pipe.
`ifndef POINT_SCALE_ROTATE_TRANSLATE_MACROS_SVH
`define POINT_SCALE_ROTATE_TRANSLATE_MACROS_SVH
// Assert that ante implies cons in the same cycle, outside reset.
`define PSRT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Assert that ante implies cons in the next cycle, outside reset.
`define PSRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/core/psrt_pkg.sv -----
// ----------------------------------------------------------------------------
// psrt_pkg
// Shared types, constants and trig helpers for the point transform.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package psrt_pkg;
  localparam int FracBits  = 6;
  localparam int TrigSteps = 16;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 24;

  localparam logic [CfgIdxW-1:0] REG_SHIFT_X = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SHIFT_Y = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ANGLE   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_ZOOM    = 2'd3;

  localparam logic signed [15:0] AngleFull = 16'sd23040;
  localparam logic [14:0] QuarterTurn      = 15'd5760;

  // rotation mode derived from the configured angle
  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_ROT  = 2'd1,
    MODE_BAD  = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic signed [25:0] cos_q24;
    logic signed [25:0] sin_q24;
  } rot_t;

  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] v;
    case (i)
      0: v = 34'sd843314857;   1: v = 34'sd497837829;
      2: v = 34'sd263043837;   3: v = 34'sd133525159;
      4: v = 34'sd67021687;    5: v = 34'sd33543516;
      6: v = 34'sd16775851;    7: v = 34'sd8388437;
      8: v = 34'sd4194283;     9: v = 34'sd2097149;
      default: v = 34'sd1 <<< (30 - i);
    endcase
    return v;
  endfunction
endpackage

// ----- rtl/core/psrt_trig.sv -----
// ----------------------------------------------------------------------------
// psrt_trig
// Sine and cosine of the configured angle: quadrant split, then a CORDIC that
// runs one step a cycle over the held angle after reset and after each angle write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module psrt_trig (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [15:0]  angle,
  output psrt_pkg::rot_t      rot
);
  logic [4:0]         step;
  logic               busy;
  logic signed [33:0] x, y, z;
  logic [1:0]         quad;
  logic [1:0]         quad_next;
  logic [14:0]        res_next;
  logic [45:0]        zprod;
  logic signed [33:0] dx, dy, ang;
  logic signed [25:0] cx, sy;
  logic signed [33:0] xr, yr;

  always_comb begin
    res_next  = angle[14:0];
    quad_next = 2'd0;
    if (res_next >= psrt_pkg::QuarterTurn) begin
      res_next = res_next - psrt_pkg::QuarterTurn; quad_next = 2'd1;
    end
    if (res_next >= psrt_pkg::QuarterTurn) begin
      res_next = res_next - psrt_pkg::QuarterTurn; quad_next = 2'd2;
    end
    if (res_next >= psrt_pkg::QuarterTurn) begin
      res_next = res_next - psrt_pkg::QuarterTurn; quad_next = 2'd3;
    end
    zprod = 46'({31'd0, res_next} * 46'd299845282) + 46'd512;
    dx  = y >>> step;
    dy  = x >>> step;
    ang = psrt_pkg::atan_q30(int'(step));
    xr  = x + 34'sd32;
    yr  = y + 34'sd32;
    cx  = 26'(xr >>> 6);
    sy  = 26'(yr >>> 6);
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      step <= '0;
      busy <= 1'b1;
      quad <= quad_next;
      x    <= 34'sd652032874;
      y    <= '0;
      z    <= 34'(zprod >> 10);
    end else if (busy) begin
      if (!z[33]) begin
        x <= x - dx; y <= y + dy; z <= z - ang;
      end else begin
        x <= x + dx; y <= y - dy; z <= z + ang;
      end
      step <= step + 5'd1;
      if (step == 5'(psrt_pkg::TrigSteps - 1)) busy <= 1'b0;
    end
  end

  always_comb begin
    if (angle < 16'sd0 || angle > psrt_pkg::AngleFull) rot.mode = psrt_pkg::MODE_BAD;
    else if (angle == 16'sd0 || angle == psrt_pkg::AngleFull) rot.mode = psrt_pkg::MODE_PASS;
    else rot.mode = psrt_pkg::MODE_ROT;
    case (quad)
      2'd0: begin rot.cos_q24 = cx;  rot.sin_q24 = sy;  end
      2'd1: begin rot.cos_q24 = -sy; rot.sin_q24 = cx;  end
      2'd2: begin rot.cos_q24 = -cx; rot.sin_q24 = -sy; end
      default: begin rot.cos_q24 = sy; rot.sin_q24 = -cx; end
    endcase
  end
endmodule

// ----- rtl/core/psrt_pipe.sv -----
// ----------------------------------------------------------------------------
// psrt_pipe
// Four-stage datapath: scale, rotate products, sum with shift, round and clamp.
// A stage advances when the one after it is empty or moving.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "point_scale_rotate_translate_macros.svh"
module psrt_pipe (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  px,
  input  logic signed [15:0]  py,
  input  logic [14:0]         rad,
  input  logic signed [23:0]  shx,
  input  logic signed [23:0]  shy,
  input  logic [15:0]         zoom,
  input  psrt_pkg::rot_t      rot,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [17:0]  ox,
  output logic signed [17:0]  oy,
  output logic [16:0]         orad,
  output logic                bad
);
  localparam int M = psrt_pkg::FracBits + 12;
  logic [3:0] v;
  logic [3:0] adv;
  // stage 1
  logic signed [32:0] xs1, ys1;
  logic [30:0]        r1;
  // stage 2
  logic signed [59:0] xc2, ys2s, xs2s, yc2;
  logic signed [32:0] xs2, ys2;
  logic [30:0]        r2;
  // stage 3
  logic signed [61:0] sx3, sy3;
  logic [30:0]        r3;
  logic signed [61:0] sx_next, sy_next;
  logic signed [61:0] shx_w, shy_w;
  logic signed [17:0] ox_next, oy_next;
  logic [16:0]        orad_next;

  assign adv[3] = !v[3] || out_ready;
  assign adv[2] = !v[2] || adv[3];
  assign adv[1] = !v[1] || adv[2];
  assign adv[0] = !v[0] || adv[1];
  assign in_ready  = adv[0];
  assign out_valid = v[3];

  function automatic logic signed [17:0] rnd_sat(input logic signed [61:0] a,
                                                 input int sh);
    logic [61:0]        mag;
    logic [61:0]        q;
    logic signed [62:0] s;
    mag = a[61] ? 62'(-a) : 62'(a);
    q   = (mag + (62'd1 << (sh - 1))) >> sh;
    s   = a[61] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (s > 63'sd131071) return 18'sd131071;
    if (s < -63'sd131072) return -18'sd131072;
    return 18'(s);
  endfunction

  always_comb begin
    shx_w = 62'(shx);
    shy_w = 62'(shy);
    if (rot.mode == psrt_pkg::MODE_ROT) begin
      sx_next = 62'(xc2) - 62'(ys2s) + (shx_w <<< 36);
      sy_next = 62'(xs2s) + 62'(yc2) + (shy_w <<< 36);
    end else begin
      sx_next = 62'(xs2) + (shx_w <<< 12);
      sy_next = 62'(ys2) + (shy_w <<< 12);
    end
    if (rot.mode == psrt_pkg::MODE_ROT) begin
      ox_next = rnd_sat(sx3, M + 24);
      oy_next = rnd_sat(sy3, M + 24);
    end else begin
      ox_next = rnd_sat(sx3, M);
      oy_next = rnd_sat(sy3, M);
    end
    orad_next = 17'(rnd_sat(62'(r3), M));
  end

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else begin
      if (adv[0]) v[0] <= in_valid;
      if (adv[1]) v[1] <= v[0];
      if (adv[2]) v[2] <= v[1];
      if (adv[3]) v[3] <= v[2];
    end
    if (adv[0]) begin
      xs1 <= px * $signed({1'b0, zoom});
      ys1 <= py * $signed({1'b0, zoom});
      r1  <= rad * zoom;
    end
    if (adv[1]) begin
      xc2  <= xs1 * rot.cos_q24;
      ys2s <= ys1 * rot.sin_q24;
      xs2s <= xs1 * rot.sin_q24;
      yc2  <= ys1 * rot.cos_q24;
      xs2  <= xs1;
      ys2  <= ys1;
      r2   <= r1;
    end
    if (adv[2]) begin
      sx3 <= sx_next;
      sy3 <= sy_next;
      r3  <= r2;
    end
    if (adv[3]) begin
      bad <= (rot.mode == psrt_pkg::MODE_BAD);
      if (rot.mode == psrt_pkg::MODE_BAD) begin
        ox <= '0; oy <= '0; orad <= '0;
      end else begin
        ox <= ox_next; oy <= oy_next; orad <= orad_next;
      end
    end
  end

  `PSRT_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid, "result dropped")
  `PSRT_ASSERT_IMP(a_bad_zero, out_valid && bad, ox == 18'sd0 && orad == 17'd0, "bad not zero")
  `PSRT_ASSERT_NEXT(a_fill, in_valid && in_ready, v[0], "item lost")
endmodule

// ----- rtl/core/point_scale_rotate_translate.sv -----
// Items pass scale, products, sum and round stages; one item per cycle unless stalled.
// Sine and cosine come from a 16-step CORDIC that runs after reset and after each
// angle write; the user holds items until it is done; the block does not enforce this.
// Stalls hold full stages in place; a full pipe still accepts while the output moves.
// Reset (rst, synchronous) empties the pipe and loads zoom 1.0, no shift, angle 0.
`timescale 1ns / 1ps
module point_scale_rotate_translate (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // point_x, point_y, radius_in, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // pixel_x, pixel_y, radius_out, bad_angle, pad
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  logic signed [23:0] shx, shy;
  logic signed [15:0] angle;
  logic [15:0]        zoom;
  logic               angle_load;
  psrt_pkg::rot_t     rot;
  logic signed [17:0] ox, oy;
  logic [16:0]        orad;
  logic               bad;

  // hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      shx <= '0; shy <= '0; angle <= '0; zoom <= 16'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        psrt_pkg::REG_SHIFT_X: shx   <= cfg_data;
        psrt_pkg::REG_SHIFT_Y: shy   <= cfg_data;
        psrt_pkg::REG_ANGLE:   angle <= cfg_data[15:0];
        psrt_pkg::REG_ZOOM:    zoom  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // start the CORDIC in the cycle after an angle write, once the new angle is held
  always_ff @(posedge clk) begin
    if (rst) angle_load <= 1'b0;
    else angle_load <= cfg_we && (cfg_index == psrt_pkg::REG_ANGLE);
  end

  psrt_trig u_trig (
    .clk(clk), .rst(rst),
    .start(angle_load),
    .angle(angle), .rot(rot)
  );

  psrt_pipe u_pipe (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .px(s_axis_tdata[15:0]), .py(s_axis_tdata[31:16]), .rad(s_axis_tdata[46:32]),
    .shx(shx), .shy(shy), .zoom(zoom), .rot(rot),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .ox(ox), .oy(oy), .orad(orad), .bad(bad)
  );

  assign m_axis_tdata = {2'b0, bad, orad, oy, ox};
endmodule

// ----- bench/psrt_checker.sv -----
// ----------------------------------------------------------------------------
// psrt_checker
// Watches the point and pixel streams and the register port. Predicts each
// transformed pixel and compares it, in order, with what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module psrt_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  typedef struct {
    logic signed [17:0] px;
    logic signed [17:0] py;
    logic [16:0]        rad;
    logic               bad;
  } pixel_t;

  longint shift_x_q, shift_y_q, angle_q, zoom_q;
  pixel_t pixel_q[$];

  longint arctan_q30 [0:15] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768
  };

  function automatic longint round_half_away(input longint v, input int m);
    longint half;
    half = longint'(1) <<< (m - 1);
    if (v >= 0) return (v + half) >>> m;
    return -((-v + half) >>> m);
  endfunction

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // cosine and sine in Q24; quadrant split is exact, residual goes to CORDIC
  function automatic void cos_sin(input longint a, output longint c, output longint s);
    longint quad, resid, x, y, z, dx, dy, cx, sy;
    quad  = a / 5760;
    resid = a - quad * 5760;
    x = 652032874;
    y = 0;
    z = (resid * 299845282 + 512) >>> 10;
    for (int i = 0; i < psrt_pkg::TrigSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - arctan_q30[i];
      end else begin
        x = x + dx; y = y - dy; z = z + arctan_q30[i];
      end
    end
    cx = (x + 32) >>> 6;
    sy = (y + 32) >>> 6;
    case (quad[1:0])
      2'd0: begin c = cx;  s = sy;  end
      2'd1: begin c = -sy; s = cx;  end
      2'd2: begin c = -cx; s = -sy; end
      default: begin c = sy; s = -cx; end
    endcase
  endfunction

  function automatic pixel_t transform_point(input logic [47:0] d);
    pixel_t r;
    longint px, py, rin, xs, ys, ox, oy, orad, c, s;
    int m;
    m   = psrt_pkg::FracBits + 12;
    px  = longint'($signed(d[15:0]));
    py  = longint'($signed(d[31:16]));
    rin = longint'(d[46:32]);
    if (angle_q < 0 || angle_q > 23040) begin
      r.px = '0; r.py = '0; r.rad = '0; r.bad = 1'b1;
      return r;
    end
    xs = px * zoom_q;
    ys = py * zoom_q;
    if (angle_q == 0 || angle_q == 23040) begin
      ox = round_half_away(xs + shift_x_q * 4096, m);
      oy = round_half_away(ys + shift_y_q * 4096, m);
    end else begin
      cos_sin(angle_q, c, s);
      ox = round_half_away(xs * c - ys * s + (shift_x_q <<< 36), m + 24);
      oy = round_half_away(xs * s + ys * c + (shift_y_q <<< 36), m + 24);
    end
    orad  = round_half_away(rin * zoom_q, m);
    r.px  = 18'(sat(ox, -131072, 131071));
    r.py  = 18'(sat(oy, -131072, 131071));
    r.rad = 17'(sat(orad, 0, 131071));
    r.bad = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      shift_x_q = 0; shift_y_q = 0; angle_q = 0; zoom_q = 4096;
      pixel_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          psrt_pkg::REG_SHIFT_X: shift_x_q = longint'($signed(cfg_data));
          psrt_pkg::REG_SHIFT_Y: shift_y_q = longint'($signed(cfg_data));
          psrt_pkg::REG_ANGLE:   angle_q   = longint'($signed(cfg_data[15:0]));
          psrt_pkg::REG_ZOOM:    zoom_q    = longint'(cfg_data[15:0]);
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) pixel_q.push_back(transform_point(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixel_q.size() == 0) begin
          $error("unexpected pixel item %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = pixel_q.pop_front();
          if (m_axis_tdata[17:0] !== want.px) begin
            $error("pixel_x: expected %0d, actual %0d", want.px, $signed(m_axis_tdata[17:0]));
            fail_count++;
          end
          if (m_axis_tdata[35:18] !== want.py) begin
            $error("pixel_y: expected %0d, actual %0d", want.py, $signed(m_axis_tdata[35:18]));
            fail_count++;
          end
          if (m_axis_tdata[52:36] !== want.rad) begin
            $error("radius_out: expected %0d, actual %0d", want.rad, m_axis_tdata[52:36]);
            fail_count++;
          end
          if (m_axis_tdata[53] !== want.bad) begin
            $error("bad_angle: expected %0d, actual %0d", want.bad, m_axis_tdata[53]);
            fail_count++;
          end
        end
      end
    end
    pending = pixel_q.size();
  end
endmodule

// ----- bench/point_scale_rotate_translate_tb.sv -----
// ----------------------------------------------------------------------------
// point_scale_rotate_translate_tb
// Drives directed and random points through the transform under several
// register settings and idle patterns; the checker judges every pixel item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module point_scale_rotate_translate_tb;
  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // point_x, point_y, radius_in, zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;   // pixel_x, pixel_y, radius_out, bad_angle, pad
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;
  int          fail_count;
  int          pending;
  int          send_idle_pct;
  int          recv_idle_pct;
  longint      cycle_count;

  point_scale_rotate_translate u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  psrt_checker u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: stall at random at the current rate.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: drop out with a failure if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one point; hold valid high across back-to-back items.
  task automatic send_point(input logic signed [15:0] px, input logic signed [15:0] py,
                            input logic [14:0] rad);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, rad, py, px};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Drain the pipe so registers can change while the block is idle.
  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write all four registers, then give the CORDIC time to settle.
  task automatic load_regs(input logic [23:0] sx, input logic [23:0] sy,
                           input logic signed [15:0] ang, input logic [15:0] zm);
    cfg_we <= 1'b1; cfg_index <= psrt_pkg::REG_SHIFT_X; cfg_data <= sx;
    @(posedge clk);
    cfg_index <= psrt_pkg::REG_SHIFT_Y; cfg_data <= sy;
    @(posedge clk);
    cfg_index <= psrt_pkg::REG_ANGLE; cfg_data <= {8'h00, ang};
    @(posedge clk);
    cfg_index <= psrt_pkg::REG_ZOOM; cfg_data <= {8'h00, zm};
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(256)) - 16'd128;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(9))
      0: return 16'($urandom);                   // mostly out of range
      1: return 16'($urandom_range(3)) * 16'(psrt_pkg::QuarterTurn);
      2: return 16'(psrt_pkg::AngleFull);
      default: return 16'($urandom_range(23040));
    endcase
  endfunction

  function automatic logic [23:0] rand_shift();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return $urandom_range(1) ? 24'h800000 : 24'h7FFFFF;
      default: return 24'($urandom_range(4096)) - 24'd2048;
    endcase
  endfunction

  function automatic logic [15:0] rand_zoom();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return $urandom_range(1) ? 16'h0000 : 16'hFFFF;
      default: return 16'($urandom_range(8192, 1024));
    endcase
  endfunction

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = psrt_pkg::REG_SHIFT_X;
    cfg_data      = '0;
    cycle_count   = 0;
    send_idle_pct = 12;
    recv_idle_pct = 66;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (20) @(posedge clk);

    // Directed: reset settings, field extremes, rounding halves.
    send_point(16'h0000, 16'h0000, 15'd0);
    send_point(16'h7FFF, 16'h8000, 15'h7FFF);
    send_point(16'h8000, 16'h7FFF, 15'd32);
    send_point(16'd32, -16'sd32, 15'd96);
    send_point(-16'sd96, 16'd160, 15'd1);
    drain_pipe();

    // Full turn, quadrants, and a mid-quadrant angle.
    load_regs(24'd100, -24'sd100, psrt_pkg::AngleFull, 16'd4096);
    send_point(16'd640, -16'sd320, 15'd64);
    drain_pipe();
    load_regs(24'd0, 24'd0, 16'(psrt_pkg::QuarterTurn), 16'd4096);
    send_point(16'd640, 16'd0, 15'd64);
    send_point(16'h7FFF, 16'h8000, 15'h7FFF);
    drain_pipe();
    load_regs(24'd0, 24'd0, 16'd11520, 16'd4096);
    send_point(16'd640, 16'd320, 15'd64);
    drain_pipe();
    load_regs(24'd64, 24'd64, 16'd17280, 16'd4096);
    send_point(16'd640, 16'd320, 15'd64);
    drain_pipe();
    load_regs(24'h7FFFFF, 24'h800000, 16'd2880, 16'hFFFF);
    send_point(16'h7FFF, 16'h7FFF, 15'h7FFF);
    send_point(16'h8000, 16'h8000, 15'd0);
    drain_pipe();

    // Out-of-range angles: just below zero, just above a full turn, extremes.
    load_regs(24'd1000, 24'd1000, -16'sd1, 16'd4096);
    send_point(16'd640, 16'd640, 15'd64);
    drain_pipe();
    load_regs(24'd0, 24'd0, 16'd23041, 16'd4096);
    send_point(16'd640, 16'd640, 15'd64);
    drain_pipe();
    load_regs(24'd0, 24'd0, 16'h8000, 16'd4096);
    send_point(16'd640, 16'd640, 15'd64);
    drain_pipe();
    load_regs(24'd0, 24'd0, 16'h7FFF, 16'd4096);
    send_point(16'd1, 16'd1, 15'd1);
    drain_pipe();

    // Zero zoom collapses everything onto the shift.
    load_regs(24'h800000, 24'h7FFFFF, 16'd1000, 16'h0000);
    send_point(16'h7FFF, 16'h8000, 15'h7FFF);
    drain_pipe();

    // Random: twelve register settings; each drain doubles as the pause
    // that lets every outstanding pixel come back before the sender goes on.
    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 4) begin
        send_idle_pct = 66;
        recv_idle_pct = 12;
      end else if (phase == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      load_regs(rand_shift(), rand_shift(), rand_angle(), rand_zoom());
      for (int n = 0; n < 40; n++)
        send_point(rand_coord(), rand_coord(), 15'($urandom));
      drain_pipe();
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/psrt_pkg.sv
rtl/core/psrt_trig.sv
rtl/core/psrt_pipe.sv
rtl/core/point_scale_rotate_translate.sv
bench/psrt_checker.sv
bench/point_scale_rotate_translate_tb.sv
